/* rtl/core/sliding_window_first_negative_unit_assert.svh */
// Assertion macros used by swfn_ctl. Clock clk, reset rst_n (active low).
`ifndef SLIDING_WINDOW_FIRST_NEGATIVE_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_FIRST_NEGATIVE_UNIT_ASSERT_SVH

`define SWFN_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define SWFN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define SWFN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/swfn_pkg.sv */
package swfn_pkg;

  localparam int WindowMax = 64;
  localparam int SampleW   = 32;
  localparam int PosW      = 8;
  localparam int WsW       = 7;
  localparam int PtrW      = $clog2(WindowMax);
  localparam int CntW      = $clog2(WindowMax + 1);

  typedef struct packed {
    logic [SampleW-1:0] value;
    logic [PosW-1:0]    stamp;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic               step;
    logic [SampleW-1:0] sample;
    logic               last;
  } step_t;

  typedef struct packed {
    logic               produce;
    logic [SampleW-1:0] value;
    logic               found;
    logic               eos;
  } result_t;

  // Window size with zero taken as one and large values saturated.
  function automatic logic [WsW-1:0] clamp_window(input logic [WsW-1:0] ws);
    logic [WsW-1:0] k;
    k = ws;
    if (ws == '0) begin
      k = WsW'(1);
    end else if ({1'b0, ws} > (WsW + 1)'(WindowMax)) begin
      k = WsW'(WindowMax);
    end
    return k;
  endfunction

endpackage

/* rtl/core/swfn_ram.sv */
module swfn_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/swfn_ctl.sv */
module swfn_ctl (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [swfn_pkg::WsW-1:0]              cfg_data,
  input  swfn_pkg::step_t                       step_in,
  output swfn_pkg::result_t                     res,
  output logic                                  ram_we,
  output logic [swfn_pkg::PtrW-1:0]             ram_waddr,
  output logic [swfn_pkg::EntryW-1:0]           ram_wdata,
  output logic [swfn_pkg::PtrW-1:0]             ram_raddr,
  input  logic [swfn_pkg::EntryW-1:0]           ram_rdata
);
  import swfn_pkg::*;
  `include "sliding_window_first_negative_unit_assert.svh"

  logic [WsW-1:0]  ws_r;
  logic [PtrW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [CntW-1:0] fill_r, fill_nxt;
  entry_t          head_ent_r, head_ent_nxt;
  logic            byp_vld_r, byp_vld_nxt;
  entry_t          byp_ent_r;

  logic [WsW-1:0]  k;
  entry_t          next_ent;
  entry_t          new_ent;
  logic [PosW-1:0] age;
  logic            neg, pop, push;
  logic [PtrW-1:0] head1;
  logic [CntW-1:0] cnt1, cnt2;

  always_comb begin
    k        = clamp_window(ws_r);
    next_ent = byp_vld_r ? byp_ent_r : entry_t'(ram_rdata);
    new_ent  = '{value: step_in.sample, stamp: pos_r};
    neg      = step_in.sample[SampleW-1];
    age      = pos_r - head_ent_r.stamp;
    pop      = (cnt_r != '0) && ({1'b0, age} >= (PosW + 1)'(k));
    head1    = pop ? head_r + PtrW'(1) : head_r;
    cnt1     = cnt_r - {{(CntW-1){1'b0}}, pop};
    push     = neg && (cnt1 != CntW'(WindowMax));
    cnt2     = cnt1 + {{(CntW-1){1'b0}}, push};

    if (cnt1 == '0) begin
      head_ent_nxt = new_ent;
    end else if (pop) begin
      head_ent_nxt = next_ent;
    end else begin
      head_ent_nxt = head_ent_r;
    end

    res.produce = step_in.step && (({1'b0, fill_r} + (CntW + 1)'(1)) >= (CntW + 1)'(k));
    res.found   = (cnt2 != '0);
    res.value   = res.found ? head_ent_nxt.value : '0;
    res.eos     = step_in.last;

    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    if (step_in.step) begin
      if (step_in.last) begin
        head_nxt = '0;
        tail_nxt = '0;
        cnt_nxt  = '0;
        pos_nxt  = '0;
        fill_nxt = '0;
      end else begin
        head_nxt = head1;
        tail_nxt = push ? tail_r + PtrW'(1) : tail_r;
        cnt_nxt  = cnt2;
        pos_nxt  = pos_r + PosW'(1);
        fill_nxt = (fill_r != CntW'(WindowMax)) ? fill_r + CntW'(1) : fill_r;
      end
    end

    ram_we      = step_in.step && push;
    ram_waddr   = tail_r;
    ram_wdata   = EntryW'(new_ent);
    // Prefetch the entry behind the head; same-edge write is forwarded.
    ram_raddr   = head_nxt + PtrW'(1);
    byp_vld_nxt = ram_we && (ram_waddr == ram_raddr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r      <= WsW'(1);
      head_r    <= '0;
      tail_r    <= '0;
      cnt_r     <= '0;
      pos_r     <= '0;
      fill_r    <= '0;
      byp_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ws_r <= cfg_data;
      end
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      cnt_r     <= cnt_nxt;
      pos_r     <= pos_nxt;
      fill_r    <= fill_nxt;
      byp_vld_r <= byp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_ent_r <= new_ent;
    if (step_in.step) begin
      head_ent_r <= head_ent_nxt;
    end
  end

  `SWFN_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CntW'(WindowMax), "entry count above capacity")
  `SWFN_ASSERT_ALWAYS(a_ptr_cnt, PtrW'(tail_r - head_r) == cnt_r[PtrW-1:0], "pointers and count disagree")
  `SWFN_ASSERT_NEXT(a_last_clear, step_in.step && step_in.last, cnt_r == '0 && fill_r == '0 && pos_r == '0, "state not cleared after last")
  `SWFN_ASSERT_IMPL(a_found_neg, res.produce && res.found, res.value[SampleW-1], "found value not negative")

endmodule

/* rtl/core/sliding_window_first_negative_unit.sv */
// Channel  Direction  Transfer when             Payload
// in_      slave      in_tvalid & in_tready     tdata: sample; tlast: last_item
// out_     master     out_tvalid & out_tready   tdata: first_negative; tuser: found;
//                                               tlast: end_of_sequence
// cfg_     write      cfg_wr_en                 cfg_wr_data: window_size
//
// One sample per cycle unless stalled; a result shows the cycle after its input.
// Queue entries live in a 64x40 RAM; the head entry is cached in flops and the
// entry behind it is prefetched every cycle, with same-edge writes forwarded.
// Output register stalls input only while a result is held and out_tready is low.
// rst_n is synchronous; no clearing pass, the queue is usable right after reset.
module sliding_window_first_negative_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [swfn_pkg::WsW-1:0]    cfg_wr_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [swfn_pkg::SampleW-1:0] in_tdata,   // [31:0] sample
  input  logic                        in_tlast,   // last_item
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [swfn_pkg::SampleW-1:0] out_tdata,  // [31:0] first_negative
  output logic                        out_tuser,  // [0] found
  output logic                        out_tlast   // end_of_sequence
);
  import swfn_pkg::*;

  step_t              step;
  result_t            res;
  logic               ram_we;
  logic [PtrW-1:0]    ram_waddr, ram_raddr;
  logic [EntryW-1:0]  ram_wdata, ram_rdata;

  logic               out_vld_r, out_vld_nxt;
  logic [SampleW-1:0] out_data_r;
  logic               out_found_r, out_last_r;

  assign in_tready   = !out_vld_r || out_tready;
  assign step.step   = in_tvalid && in_tready;
  assign step.sample = in_tdata;
  assign step.last   = in_tlast;

  swfn_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_wr_en),
    .cfg_data  (cfg_wr_data),
    .step_in   (step),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  swfn_ram #(
    .Width (EntryW),
    .Depth (WindowMax)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_vld_nxt = out_vld_r && !out_tready;
    if (res.produce) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.produce) begin
      out_data_r  <= res.value;
      out_found_r <= res.found;
      out_last_r  <= res.eos;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int PtrW       = $clog2(swfn_pkg::WindowMax);
  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 3;

  typedef struct packed {
    logic [swfn_pkg::SampleW-1:0] value;
    logic                         found;
    logic                         eos;
  } window_result_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_HALF,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_e;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_wr_en = 1'b0;
  logic [swfn_pkg::WsW-1:0]     cfg_wr_data = '0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [swfn_pkg::SampleW-1:0] in_tdata = '0;   // [31:0] sample
  logic                         in_tlast = 1'b0; // last_item
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [swfn_pkg::SampleW-1:0] out_tdata;       // [31:0] first_negative
  logic                         out_tuser;       // [0] found
  logic                         out_tlast;       // end_of_sequence

  // window tracker state
  logic [swfn_pkg::SampleW-1:0] neg_value [swfn_pkg::WindowMax];
  logic [swfn_pkg::PosW-1:0]    neg_stamp [swfn_pkg::WindowMax];
  logic [PtrW-1:0]              head_idx;
  logic [PtrW-1:0]              tail_idx;
  int unsigned                  neg_count;
  int unsigned                  filled;
  logic [swfn_pkg::PosW-1:0]    position;
  logic [swfn_pkg::WsW-1:0]     window_cfg;

  window_result_t pending_results[$];
  window_result_t want;

  int unsigned errors;
  int unsigned samples_sent;
  int unsigned sequences_done;
  int unsigned windows_checked;
  int unsigned negatives_found;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned rx_left;
  rx_mode_e    rx_mode;

  sliding_window_first_negative_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t timeout, %0d results still pending", $time, pending_results.size());
      $display("FAIL sliding_window_first_negative_unit");
      $finish;
    end
  end

  function automatic int unsigned effective_window(input logic [swfn_pkg::WsW-1:0] w);
    if (w == '0) begin
      return 1;
    end
    if (int'(w) > swfn_pkg::WindowMax) begin
      return swfn_pkg::WindowMax;
    end
    return int'(w);
  endfunction

  function automatic void clear_window_state();
    head_idx  = '0;
    tail_idx  = '0;
    neg_count = 0;
    filled    = 0;
    position  = '0;
  endfunction

  // one sample through the window tracker; queues the result it gives
  function automatic void track_sample(input logic [swfn_pkg::SampleW-1:0] s,
                                       input logic last);
    int unsigned               k;
    logic [swfn_pkg::PosW-1:0] age;
    window_result_t            r;
    k = effective_window(window_cfg);
    if (neg_count > 0) begin
      age = position - neg_stamp[head_idx];
      if (int'(age) >= k) begin
        head_idx = head_idx + 1'b1;
        neg_count--;
      end
    end
    if (s[swfn_pkg::SampleW-1] && neg_count < swfn_pkg::WindowMax) begin
      neg_value[tail_idx] = s;
      neg_stamp[tail_idx] = position;
      tail_idx = tail_idx + 1'b1;
      neg_count++;
    end
    if (filled + 1 >= k) begin
      r.found = (neg_count > 0);
      r.value = r.found ? neg_value[head_idx] : '0;
      r.eos   = last;
      pending_results.insert(pending_results.size(), r);
    end
    if (filled < swfn_pkg::WindowMax) begin
      filled++;
    end
    position = position + 1'b1;
    if (last) begin
      clear_window_state();
      sequences_done++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual data=%h found=%b eos=%b",
                 $time, out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        windows_checked++;
        if (want.found) begin
          negatives_found++;
        end
        if (out_tdata !== want.value) begin
          $display("%0t first_negative mismatch: expected %h, actual %h",
                   $time, want.value, out_tdata);
          errors++;
        end
        if (out_tuser !== want.found) begin
          $display("%0t found mismatch: expected %b, actual %b", $time, want.found, out_tuser);
          errors++;
        end
        if (out_tlast !== want.eos) begin
          $display("%0t end_of_sequence mismatch: expected %b, actual %b",
                   $time, want.eos, out_tlast);
          errors++;
        end
      end
    end
  end

  // receiver: stall patterns, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(4, 60);
      end
      rx_left--;
      case (rx_mode)
        RX_STEADY: out_tready <= 1'b1;
        RX_HALF:   out_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_sample(input logic [swfn_pkg::SampleW-1:0] s, input logic last);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    track_sample(s, last);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic pause_input(input int unsigned cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // sender in bursts with random gaps
  task automatic offer_sample(input logic [swfn_pkg::SampleW-1:0] s, input logic last);
    if (burst_left == 0) begin
      pause_input($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
    end
    send_sample(s, last);
    burst_left--;
  endtask

  task automatic wait_quiet();
    pause_input(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_window(input logic [swfn_pkg::WsW-1:0] w);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    window_cfg = w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [swfn_pkg::SampleW-1:0] make_sample(input int unsigned neg_pct);
    logic [swfn_pkg::SampleW-1:0] v;
    case ($urandom_range(0, 15))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      2:       v = 32'hFFFF_FFFF;
      3:       v = '0;
      default: v = $urandom;
    endcase
    if (v != '0) begin
      v[swfn_pkg::SampleW-1] = ($urandom_range(0, 99) < neg_pct);
    end
    return v;
  endfunction

  task automatic test_single_window();
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0001, 1'b1);
    wait_quiet();
  endtask

  task automatic test_window_clamp();
    set_window('0);
    send_sample(32'hFFFF_FFFD, 1'b0);
    send_sample(32'h0000_0005, 1'b0);
    send_sample(32'h8000_0001, 1'b1);
    wait_quiet();
    // saturates to the largest window; sequence too short to give a result
    set_window('1);
    send_sample(32'hFFFF_FF00, 1'b0);
    send_sample(32'h0000_0010, 1'b0);
    send_sample(32'hC000_0000, 1'b0);
    send_sample(32'h1234_5678, 1'b1);
    wait_quiet();
  endtask

  task automatic test_window_resize();
    set_window(7'd4);
    send_sample(32'hFFFF_FFF1, 1'b0);
    send_sample(32'hFFFF_FFF2, 1'b0);
    send_sample(32'h0000_0003, 1'b0);
    send_sample(32'hFFFF_FFF4, 1'b0);
    send_sample(32'h0000_0005, 1'b0);
    send_sample(32'hFFFF_FFF6, 1'b0);
    wait_quiet();
    // shrink mid-sequence: stale entries leave one per sample
    set_window(7'd1);
    send_sample(32'h0000_0007, 1'b0);
    send_sample(32'h0000_0008, 1'b0);
    send_sample(32'hFFFF_FFF9, 1'b1);
    wait_quiet();
  endtask

  task automatic test_output_stall();
    set_window(7'd2);
    hold_request = 160;
    for (int i = 0; i < 24; i++) begin
      send_sample(make_sample(50), (i == 23));
    end
    wait_quiet();
  endtask

  task automatic test_random_sequences();
    int unsigned random_items;
    int unsigned k;
    int unsigned len;
    int unsigned split_at;
    int unsigned neg_pct;
    logic [swfn_pkg::WsW-1:0] w;
    random_items = 0;
    while (random_items < 900) begin
      case ($urandom_range(0, 9))
        0:       w = 7'd1;
        1:       w = 7'd64;
        2:       w = 7'd0;
        3:       w = 7'($urandom_range(65, 127));
        default: w = 7'($urandom_range(1, 64));
      endcase
      k = effective_window(w);
      case ($urandom_range(0, 29))
        0:       len = $urandom_range(260, 320);
        1, 2:    len = (k > 1) ? $urandom_range(1, k - 1) : 1;
        default: len = k + $urandom_range(0, 40);
      endcase
      case ($urandom_range(0, 4))
        0:       neg_pct = 0;
        1:       neg_pct = 15;
        2:       neg_pct = 50;
        3:       neg_pct = 90;
        default: neg_pct = 100;
      endcase
      split_at = ($urandom_range(0, 3) == 0 && len > 2) ? $urandom_range(1, len - 1) : 0;
      set_window(w);
      for (int unsigned i = 0; i < len; i++) begin
        if (i == split_at && i != 0) begin
          wait_quiet();
          set_window(7'($urandom_range(0, 127)));
        end
        offer_sample(make_sample(neg_pct), (i == len - 1));
        random_items++;
      end
      wait_quiet();
    end
  endtask

  initial begin
    window_cfg = 7'd1;
    clear_window_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_single_window();
    test_window_clamp();
    test_window_resize();
    test_output_stall();
    test_random_sequences();

    $display("Run covered %0d samples in %0d sequences, window sizes 0..127 incl. resizing",
             samples_sent, sequences_done);
    $display("%0d windows checked, %0d with a negative found", windows_checked,
             negatives_found);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS sliding_window_first_negative_unit");
    end else begin
      $display("FAIL sliding_window_first_negative_unit");
    end
    $finish;
  end

endmodule
